// ===== src/aof_pkg.sv =====
// Package: shared types, constants and register codes of the alpha outline filter.
`timescale 1ns / 1ps
package aof_pkg;

    // Sprite geometry limits
    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int WCNT_W     = COL_W + 1;
    localparam int ROW_W      = $clog2(MAX_HEIGHT + 1);

    // Register field widths
    localparam int GEOM_W  = 9;
    localparam int ALPHA_W = 8;
    localparam int PIX_W   = 32;
    localparam int ALPHA_LSB = 24;

    // APB port
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 5;

    // Register index codes
    typedef enum logic [2:0] {
        REG_SPRITE_WIDTH    = 3'd0,
        REG_SPRITE_HEIGHT   = 3'd1,
        REG_OUTLINE_ENABLE  = 3'd2,
        REG_ALPHA_THRESHOLD = 3'd3,
        REG_OUTLINE_COLOR   = 3'd4
    } reg_idx_t;

    // Reset values
    localparam logic [GEOM_W-1:0]  RST_WIDTH     = 9'd16;
    localparam logic [GEOM_W-1:0]  RST_HEIGHT    = 9'd16;
    localparam logic               RST_ENABLE    = 1'b1;
    localparam logic [ALPHA_W-1:0] RST_THRESHOLD = 8'd100;
    localparam logic [PIX_W-1:0]   RST_COLOR     = 32'hFF14_080E;

    // Input beat
    typedef struct packed {
        logic             op;
        logic [PIX_W-1:0] pixel_in;
    } px_beat_t;

    // Result beat
    typedef struct packed {
        logic [PIX_W-1:0] pixel_out;
        logic             last;
    } res_beat_t;

    // Configuration as seen by the datapath
    typedef struct packed {
        logic [GEOM_W-1:0]  sprite_width;
        logic [GEOM_W-1:0]  sprite_height;
        logic               outline_enable;
        logic [ALPHA_W-1:0] alpha_threshold;
        logic [PIX_W-1:0]   outline_color;
    } cfg_t;

    // Contents of one cell of the row line
    typedef struct packed {
        logic [PIX_W-1:0]   px;
        logic [ALPHA_W-1:0] above;
    } cell_data_t;

    function automatic logic [ALPHA_W-1:0] alpha_of(input logic [PIX_W-1:0] px);
        return px[ALPHA_LSB +: ALPHA_W];
    endfunction

endpackage

// ===== src/aof_cell.sv =====
// Cell: one stage of the row line, loads a new pixel or takes its left neighbor's.
`timescale 1ns / 1ps
module aof_cell (
    input  logic                           clk,
    input  logic                           shift_en,
    input  logic [aof_pkg::COL_W-1:0]      cell_idx,
    input  logic [aof_pkg::COL_W-1:0]      entry_idx,
    input  aof_pkg::cell_data_t            new_data,
    input  aof_pkg::cell_data_t            prev_data,
    output aof_pkg::cell_data_t            data
);

    aof_pkg::cell_data_t data_reg;
    aof_pkg::cell_data_t data_next;

    // The entry cell starts the line; all others pass along
    always_comb
    begin
        data_next = data_reg;
        if (shift_en)
        begin
            if (cell_idx == entry_idx)
                data_next = new_data;
            else
                data_next = prev_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

// ===== src/aof_row_chain.sv =====
// Row line: chain of cells holding one sprite row of pixels and the alphas above them.
`timescale 1ns / 1ps
module aof_row_chain (
    input  logic                           clk,
    input  logic                           shift_en,
    input  logic [aof_pkg::COL_W-1:0]      entry_idx,
    input  aof_pkg::cell_data_t            new_data,
    output aof_pkg::cell_data_t            centre,
    output aof_pkg::cell_data_t            right
);

    aof_pkg::cell_data_t cell_q [aof_pkg::MAX_WIDTH];

    // Cell i takes from cell i-1; the first cell only ever loads
    for (genvar i = 0; i < aof_pkg::MAX_WIDTH; i++)
    begin : g_cell
        aof_pkg::cell_data_t prev;
        if (i == 0)
        begin : g_first
            assign prev = new_data;
        end
        else
        begin : g_rest
            assign prev = cell_q[i-1];
        end

        aof_cell u_cell (
            .clk       (clk),
            .shift_en  (shift_en),
            .cell_idx  (aof_pkg::COL_W'(i)),
            .entry_idx (entry_idx),
            .new_data  (new_data),
            .prev_data (prev),
            .data      (cell_q[i])
        );
    end

    // Oldest entry is the centre; the one behind it is its right neighbor
    assign centre = cell_q[aof_pkg::MAX_WIDTH-1];
    assign right  = cell_q[aof_pkg::MAX_WIDTH-2];

endmodule

// ===== src/aof_regs.sv =====
// Register file: APB access to the filter's configuration registers.
`timescale 1ns / 1ps
module aof_regs (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [aof_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [aof_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [aof_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready,
    output aof_pkg::cfg_t                     cfg
);

    aof_pkg::cfg_t    cfg_reg;
    aof_pkg::cfg_t    cfg_next;
    aof_pkg::reg_idx_t reg_sel;
    logic             wr_en;

    assign pready  = 1'b1;
    assign reg_sel = aof_pkg::reg_idx_t'(paddr[aof_pkg::APB_ADDR_W-1:2]);
    assign wr_en   = psel && penable && pwrite && pready;

    // Write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_sel)
                aof_pkg::REG_SPRITE_WIDTH:
                    cfg_next.sprite_width = pwdata[aof_pkg::GEOM_W-1:0];
                aof_pkg::REG_SPRITE_HEIGHT:
                    cfg_next.sprite_height = pwdata[aof_pkg::GEOM_W-1:0];
                aof_pkg::REG_OUTLINE_ENABLE:
                    cfg_next.outline_enable = pwdata[0];
                aof_pkg::REG_ALPHA_THRESHOLD:
                    cfg_next.alpha_threshold = pwdata[aof_pkg::ALPHA_W-1:0];
                aof_pkg::REG_OUTLINE_COLOR:
                    cfg_next.outline_color = pwdata[aof_pkg::PIX_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sprite_width    <= aof_pkg::RST_WIDTH;
            cfg_reg.sprite_height   <= aof_pkg::RST_HEIGHT;
            cfg_reg.outline_enable  <= aof_pkg::RST_ENABLE;
            cfg_reg.alpha_threshold <= aof_pkg::RST_THRESHOLD;
            cfg_reg.outline_color   <= aof_pkg::RST_COLOR;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Read mux
    always_comb
    begin
        prdata = '0;
        case (reg_sel)
            aof_pkg::REG_SPRITE_WIDTH:
                prdata = aof_pkg::APB_DATA_W'(cfg_reg.sprite_width);
            aof_pkg::REG_SPRITE_HEIGHT:
                prdata = aof_pkg::APB_DATA_W'(cfg_reg.sprite_height);
            aof_pkg::REG_OUTLINE_ENABLE:
                prdata = aof_pkg::APB_DATA_W'(cfg_reg.outline_enable);
            aof_pkg::REG_ALPHA_THRESHOLD:
                prdata = aof_pkg::APB_DATA_W'(cfg_reg.alpha_threshold);
            aof_pkg::REG_OUTLINE_COLOR:
                prdata = aof_pkg::APB_DATA_W'(cfg_reg.outline_color);
            default:
                prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

// ===== src/alpha_outline_filter.sv =====
// Top level: four-neighbor alpha outline filter over a raster pixel stream.
// Latency: a pixel's result leaves one sprite row (sprite_width beats) after it enters,
//   registered in the output register when the beat that releases it is accepted.
// Throughput: one beat per cycle barring px_stall; each beat shifts all MAX_WIDTH cells.
// Reset: counters, left alpha, output valid and registers return to defaults at once;
//   the row line cells are not cleared, the first row of each sprite fills them.
`timescale 1ns / 1ps
module alpha_outline_filter (
    input  logic                              clk,
    input  logic                              rst_n,
    // APB configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [aof_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [aof_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [aof_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready,
    // Pixel input channel
    input  logic                              px_valid,
    output logic                              px_stall,
    input  aof_pkg::px_beat_t                 px_beat,
    // Result channel
    output logic                              res_valid,
    input  logic                              res_stall,
    output aof_pkg::res_beat_t                res_beat
);

    aof_pkg::cfg_t cfg;

    logic [aof_pkg::COL_W-1:0]  col_reg;
    logic [aof_pkg::COL_W-1:0]  col_next;
    logic [aof_pkg::ROW_W-1:0]  row_reg;
    logic [aof_pkg::ROW_W-1:0]  row_next;
    logic [aof_pkg::ALPHA_W-1:0] left_reg;
    logic [aof_pkg::ALPHA_W-1:0] left_next;
    logic                        res_valid_reg;
    logic                        res_valid_next;
    aof_pkg::res_beat_t          res_beat_reg;
    aof_pkg::res_beat_t          res_beat_next;

    logic                         accept;
    logic [aof_pkg::WCNT_W-1:0]   w_eff;
    logic [aof_pkg::ROW_W-1:0]    h_eff;
    logic [aof_pkg::COL_W-1:0]    col;
    logic [aof_pkg::ROW_W-1:0]    row;
    logic [aof_pkg::WCNT_W-1:0]   col_inc;
    logic [aof_pkg::PIX_W-1:0]    eff;
    logic                         has_out;
    logic [aof_pkg::ALPHA_W-1:0]  ca;
    logic [aof_pkg::ALPHA_W-1:0]  up;
    logic [aof_pkg::ALPHA_W-1:0]  down;
    logic [aof_pkg::ALPHA_W-1:0]  lf;
    logic [aof_pkg::ALPHA_W-1:0]  rt;
    logic                         hit;
    logic [aof_pkg::COL_W-1:0]    entry_idx;
    aof_pkg::cell_data_t          new_data;
    aof_pkg::cell_data_t          centre;
    aof_pkg::cell_data_t          right;

    aof_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Handshake: take a beat unless a held result is stalled
    assign px_stall = res_valid_reg && res_stall;
    assign accept   = px_valid && !px_stall;

    // Effective geometry
    always_comb
    begin
        if (cfg.sprite_width == '0)
            w_eff = aof_pkg::WCNT_W'(1);
        else if (int'(cfg.sprite_width) > aof_pkg::MAX_WIDTH)
            w_eff = aof_pkg::WCNT_W'(aof_pkg::MAX_WIDTH);
        else
            w_eff = aof_pkg::WCNT_W'(cfg.sprite_width);

        if (cfg.sprite_height == '0)
            h_eff = aof_pkg::ROW_W'(1);
        else if (int'(cfg.sprite_height) > aof_pkg::MAX_HEIGHT)
            h_eff = aof_pkg::ROW_W'(aof_pkg::MAX_HEIGHT);
        else
            h_eff = aof_pkg::ROW_W'(cfg.sprite_height);
    end

    // New entries start at the cell that is w_eff beats from the end
    assign entry_idx = aof_pkg::COL_W'(aof_pkg::WCNT_W'(aof_pkg::MAX_WIDTH) - w_eff);

    // Position of this beat, wrapped if the geometry shrank
    assign col     = ({1'b0, col_reg} >= w_eff) ? '0 : col_reg;
    assign row     = (row_reg > h_eff) ? '0 : row_reg;
    assign col_inc = {1'b0, col} + aof_pkg::WCNT_W'(1);

    // Flush row and op=1 beats are transparent zeros
    assign eff     = (px_beat.op || (row >= h_eff)) ? '0 : px_beat.pixel_in;
    assign has_out = (row != '0);

    // Cross neighborhood around the centre pixel
    assign ca   = aof_pkg::alpha_of(centre.px);
    assign up   = (row >= aof_pkg::ROW_W'(2)) ? centre.above : '0;
    assign down = aof_pkg::alpha_of(eff);
    assign lf   = (col != '0) ? left_reg : '0;
    assign rt   = (col_inc < w_eff) ? aof_pkg::alpha_of(right.px) : '0;

    assign hit = cfg.outline_enable && (ca == '0) &&
                 ((up > cfg.alpha_threshold) || (down > cfg.alpha_threshold) ||
                  (lf > cfg.alpha_threshold) || (rt > cfg.alpha_threshold));

    assign new_data.px    = eff;
    assign new_data.above = ca;

    aof_row_chain u_chain (
        .clk       (clk),
        .shift_en  (accept),
        .entry_idx (entry_idx),
        .new_data  (new_data),
        .centre    (centre),
        .right     (right)
    );

    // Counters and left neighbor
    always_comb
    begin
        col_next  = col_reg;
        row_next  = row_reg;
        left_next = left_reg;
        if (accept)
        begin
            if (has_out)
                left_next = ca;
            if (col_inc >= w_eff)
            begin
                col_next = '0;
                if (row >= h_eff)
                    row_next = '0;
                else
                    row_next = row + aof_pkg::ROW_W'(1);
            end
            else
            begin
                col_next = col_inc[aof_pkg::COL_W-1:0];
                row_next = row;
            end
        end
    end

    // Output register
    always_comb
    begin
        res_valid_next = res_valid_reg;
        res_beat_next  = res_beat_reg;
        if (accept)
        begin
            res_valid_next          = has_out;
            res_beat_next.pixel_out = hit ? cfg.outline_color : centre.px;
            res_beat_next.last      = (row == h_eff) && (col_inc == w_eff);
        end
        else if (res_valid_reg && !res_stall)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            left_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg       <= col_next;
            row_reg       <= row_next;
            left_reg      <= left_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_beat_reg <= res_beat_next;
    end

    assign res_valid = res_valid_reg;
    assign res_beat  = res_beat_reg;

    // A beat is held back only behind a stalled result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        px_stall |-> res_valid)
        else $error("input stalled with no result pending");

    // A beat of the first row leaves no result
    a_first_row_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !has_out) |=> !res_valid)
        else $error("result produced for a first-row beat");

    // A beat past the first row always yields a result next cycle
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && has_out) |=> res_valid)
        else $error("result missing after a beat past the first row");

    // Row counter never passes the tallest flush row
    a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
        int'(row_reg) <= aof_pkg::MAX_HEIGHT)
        else $error("row counter out of range");

endmodule
